>>> hw/rtl/nbce_pkg.sv
// ----------------------------------------------------------------------------
// nbce_pkg: shared types and constants of the nine-bit CPU execute step
// Request codes, instruction field codes, stream widths and the structs that
// pass between the execute logic, the data memory and the top level.
// ----------------------------------------------------------------------------
package nbce_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_PC_WIDTH  = 10;
  localparam int DEF_MEM_DEPTH = 256;

  // Fixed field widths.
  localparam int PC_OUT_W  = 10;
  localparam int PLEN_W    = 10;
  localparam int INSTR_W   = 9;
  localparam int BYTE_W    = 8;
  localparam int NUM_REGS  = 4;

  // Stream widths.
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Major opcodes, instruction bits 8:6.
  localparam logic [2:0] OP_JREL = 3'b111;
  localparam logic [2:0] OP_ANDI = 3'b110;
  localparam logic [2:0] OP_ORHI = 3'b101;
  localparam logic [2:0] OP_ORLO = 3'b100;
  localparam logic [2:0] OP_SHI  = 3'b011;
  localparam logic [2:0] OP_MEM  = 3'b010;
  localparam logic [2:0] OP_ALU1 = 3'b001;
  localparam logic [2:0] OP_ALU0 = 3'b000;

  // Sub-codes, instruction bits 5:4, of the memory group.
  localparam logic [1:0] SUB_BR  = 2'b11;
  localparam logic [1:0] SUB_SHR = 2'b10;
  localparam logic [1:0] SUB_ST  = 2'b01;
  localparam logic [1:0] SUB_LD  = 2'b00;

  // Sub-codes of the first ALU group.
  localparam logic [1:0] SUB_MOV = 2'b11;
  localparam logic [1:0] SUB_CMP = 2'b10;
  localparam logic [1:0] SUB_ADD = 2'b01;
  localparam logic [1:0] SUB_SUB = 2'b00;

  // Sub-codes of the second ALU group.
  localparam logic [1:0] SUB_AND  = 2'b11;
  localparam logic [1:0] SUB_OR   = 2'b10;
  localparam logic [1:0] SUB_XOR  = 2'b01;
  localparam logic [1:0] SUB_MISC = 2'b00;

  // Miscellaneous operations, instruction bits 3:2.
  localparam logic [1:0] MISC_INC = 2'b11;
  localparam logic [1:0] MISC_JR  = 2'b10;
  localparam logic [1:0] MISC_BR  = 2'b01;
  localparam logic [1:0] MISC_NIL = 2'b00;

  typedef logic [NUM_REGS-1:0][BYTE_W-1:0] regfile_t;

  typedef struct packed {
    req_t                req;
    logic [INSTR_W-1:0]  instr;
    logic [BYTE_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
  } item_t;

  typedef struct packed {
    logic              rd;
    logic              we;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    regfile_t          regs;
    logic              flag;
    logic              halted;
    logic [BYTE_W-1:0] read_data;
  } exec_res_t;

endpackage

>>> hw/rtl/nine_bit_cpu_execute_step.sv
// ----------------------------------------------------------------------------
// nine_bit_cpu_execute_step: one instruction or memory request per item
//
//   channel   dir  fields (lowest bit first)
//   s_axis    in   tuser: req_type; tdata: instr, mem_addr, mem_data
//   m_axis    out  tdata: pc_value, halted, cmp_flag, reg0..reg3, read_data
//   cfg       in   cfg_wdata: program_length, written when cfg_we is high
//
// An item is held in the execute register; loads and read requests also wait
// there for the data memory read port, which is registered. A full result
// register does not stop intake while the consumer takes the result.
// Reset clears pc, flag, registers and all memory valid bits; there is no
// clearing pass. The first item is taken the cycle after reset.
// ----------------------------------------------------------------------------
module nine_bit_cpu_execute_step #(
  parameter int PC_WIDTH  = nbce_pkg::DEF_PC_WIDTH,
  parameter int MEM_DEPTH = nbce_pkg::DEF_MEM_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nbce_pkg::PLEN_W-1:0]         cfg_wdata,   // program_length
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // instr [8:0], mem_addr [16:9], mem_data [24:17], zero [31:25]
  input  logic [nbce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type [1:0]
  input  logic [nbce_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pc_value [9:0], halted [10], cmp_flag [11], reg0 [19:12], reg1 [27:20],
  // reg2 [35:28], reg3 [43:36], read_data [51:44], zero [55:52]
  output logic [nbce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic [nbce_pkg::PLEN_W-1:0] program_length;
  logic [PC_WIDTH-1:0]         pc;
  logic [PC_WIDTH-1:0]         pc_next;
  logic                        flag;
  nbce_pkg::regfile_t          regs;

  logic                        ex_valid;
  nbce_pkg::item_t             ex_item;
  logic                        rd_phase;
  logic                        ex_done;
  logic                        s_accept;
  logic                        rd_issue;

  nbce_pkg::exec_res_t         res;
  nbce_pkg::mem_req_t          mem_req;
  logic [nbce_pkg::BYTE_W-1:0] ld_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  // An item waiting on memory finishes once its read data is back.
  assign ex_done  = ex_valid && (!mem_req.rd || rd_phase) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!ex_valid || ex_done);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign rd_issue = ex_valid && mem_req.rd && !rd_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      rd_phase <= 1'b0;
    end else begin
      if (s_accept) begin
        ex_valid <= 1'b1;
      end else if (ex_done) begin
        ex_valid <= 1'b0;
      end
      if (s_accept || ex_done) begin
        rd_phase <= 1'b0;
      end else if (rd_issue) begin
        rd_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_item <= '0;
    end else if (s_accept) begin
      ex_item.req   <= nbce_pkg::req_t'(s_axis_tuser[1:0]);
      ex_item.instr <= s_axis_tdata[8:0];
      ex_item.addr  <= s_axis_tdata[16:9];
      ex_item.data  <= s_axis_tdata[24:17];
    end
  end

  nbce_exec #(
    .PC_WIDTH (PC_WIDTH)
  ) u_exec (
    .item           (ex_item),
    .pc             (pc),
    .flag           (flag),
    .regs           (regs),
    .program_length (program_length),
    .ld_data        (ld_data),
    .pc_next        (pc_next),
    .res            (res),
    .mem_req        (mem_req)
  );

  nbce_dmem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .rd_en (rd_issue),
    .we    (ex_done && mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (ld_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      flag <= 1'b0;
      regs <= '0;
    end else if (ex_done) begin
      pc   <= pc_next;
      flag <= res.flag;
      regs <= res.regs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ex_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_done) begin
      m_axis_tdata <= {4'h0, res.read_data, res.regs[3], res.regs[2], res.regs[1],
                       res.regs[0], res.flag, res.halted,
                       nbce_pkg::PC_OUT_W'(pc_next)};
    end
  end

endmodule

>>> hw/rtl/nbce_exec.sv
// ----------------------------------------------------------------------------
// nbce_exec: instruction decode and execute
// Works out the machine state after one item from the current state, the
// item and the byte read from data memory, and forms the memory request.
// ----------------------------------------------------------------------------
module nbce_exec #(
  parameter int PC_WIDTH = nbce_pkg::DEF_PC_WIDTH
) (
  input  nbce_pkg::item_t                   item,
  input  logic [PC_WIDTH-1:0]               pc,
  input  logic                              flag,
  input  nbce_pkg::regfile_t                regs,
  input  logic [nbce_pkg::PLEN_W-1:0]       program_length,
  input  logic [nbce_pkg::BYTE_W-1:0]       ld_data,
  output logic [PC_WIDTH-1:0]               pc_next,
  output nbce_pkg::exec_res_t               res,
  output nbce_pkg::mem_req_t                mem_req
);

  localparam int CMP_W = (PC_WIDTH > nbce_pkg::PLEN_W) ? PC_WIDTH : nbce_pkg::PLEN_W;

  logic [2:0]                  op;
  logic [1:0]                  sub;
  logic [1:0]                  ra;
  logic [1:0]                  rb;
  logic [1:0]                  rs;
  logic [nbce_pkg::BYTE_W-1:0] va;
  logic [nbce_pkg::BYTE_W-1:0] vb;
  logic                        is_exec;
  logic                        halted;
  logic                        run;

  assign op  = item.instr[8:6];
  assign sub = item.instr[5:4];
  assign ra  = item.instr[3:2];
  assign rb  = item.instr[1:0];
  assign rs  = item.instr[4:3];
  assign va  = regs[ra];
  assign vb  = regs[rb];

  assign is_exec = (item.req == nbce_pkg::REQ_EXEC);
  assign halted  = is_exec && (CMP_W'(pc) >= CMP_W'(program_length));
  assign run     = is_exec && !halted;

  // Memory request: stores and loads address by register, the preload
  // requests by the address field.
  always_comb begin
    mem_req = '0;
    unique case (item.req)
      nbce_pkg::REQ_EXEC: begin
        mem_req.addr  = vb;
        mem_req.wdata = va;
        mem_req.rd    = run && (op == nbce_pkg::OP_MEM) && (sub == nbce_pkg::SUB_LD);
        mem_req.we    = run && (op == nbce_pkg::OP_MEM) && (sub == nbce_pkg::SUB_ST);
      end
      nbce_pkg::REQ_WRITE: begin
        mem_req.addr  = item.addr;
        mem_req.wdata = item.data;
        mem_req.we    = 1'b1;
      end
      nbce_pkg::REQ_READ: begin
        mem_req.addr = item.addr;
        mem_req.rd   = 1'b1;
      end
      nbce_pkg::REQ_NONE: begin
        mem_req.addr = item.addr;
      end
    endcase
  end

  always_comb begin
    pc_next       = pc;
    res.regs      = regs;
    res.flag      = flag;
    res.halted    = halted;
    res.read_data = '0;
    if (item.req == nbce_pkg::REQ_READ) begin
      res.read_data = ld_data;
    end
    if (run) begin
      pc_next = pc + PC_WIDTH'(1);
      unique case (op)
        nbce_pkg::OP_JREL: begin
          pc_next = item.instr[5] ? pc - PC_WIDTH'(item.instr[4:0])
                                  : pc + PC_WIDTH'(item.instr[4:0]);
        end
        nbce_pkg::OP_ANDI: begin
          res.regs[sub] = regs[sub] & {4'h0, item.instr[3:0]};
        end
        nbce_pkg::OP_ORHI: begin
          res.regs[sub] = regs[sub] | {item.instr[3:0], 4'h0};
        end
        nbce_pkg::OP_ORLO: begin
          res.regs[sub] = regs[sub] | {4'h0, item.instr[3:0]};
        end
        nbce_pkg::OP_SHI: begin
          if (item.instr[5]) begin
            res.regs[rs] = regs[rs] >> item.instr[2:0];
          end else begin
            res.regs[rs] = regs[rs] << item.instr[2:0];
          end
        end
        nbce_pkg::OP_MEM: begin
          unique case (sub)
            nbce_pkg::SUB_BR: begin
              if (flag) begin
                pc_next = item.instr[3] ? pc - PC_WIDTH'(item.instr[2:0])
                                        : pc + PC_WIDTH'(item.instr[2:0]);
              end
            end
            nbce_pkg::SUB_SHR: begin
              // Bit 3 of the amount register selects a left shift.
              if (vb[3]) begin
                res.regs[ra] = va << vb[2:0];
              end else begin
                res.regs[ra] = va >> vb[2:0];
              end
            end
            nbce_pkg::SUB_ST: begin
              res.regs = regs;
            end
            nbce_pkg::SUB_LD: begin
              res.regs[ra] = ld_data;
            end
          endcase
        end
        nbce_pkg::OP_ALU1: begin
          unique case (sub)
            nbce_pkg::SUB_MOV: res.regs[ra] = vb;
            nbce_pkg::SUB_CMP: res.flag     = (va == vb);
            nbce_pkg::SUB_ADD: res.regs[ra] = va + vb;
            nbce_pkg::SUB_SUB: res.regs[ra] = va - vb;
          endcase
        end
        nbce_pkg::OP_ALU0: begin
          unique case (sub)
            nbce_pkg::SUB_AND: res.regs[ra] = va & vb;
            nbce_pkg::SUB_OR:  res.regs[ra] = va | vb;
            nbce_pkg::SUB_XOR: res.regs[ra] = va ^ vb;
            nbce_pkg::SUB_MISC: begin
              unique case (ra)
                nbce_pkg::MISC_INC: res.regs[rb] = vb + 8'd1;
                nbce_pkg::MISC_JR:  pc_next = PC_WIDTH'(vb);
                nbce_pkg::MISC_BR: begin
                  if (flag) begin
                    pc_next = PC_WIDTH'(vb);
                  end
                end
                nbce_pkg::MISC_NIL: res.flag = flag;
              endcase
            end
          endcase
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/nbce_dmem.sv
// ----------------------------------------------------------------------------
// nbce_dmem: data memory
// One write and one registered read port. Each entry has a valid bit that
// reset clears, so an entry not written since reset reads as zero.
// ----------------------------------------------------------------------------
module nbce_dmem #(
  parameter int MEM_DEPTH = nbce_pkg::DEF_MEM_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic                        we,
  input  logic [nbce_pkg::BYTE_W-1:0] addr,
  input  logic [nbce_pkg::BYTE_W-1:0] wdata,
  output logic [nbce_pkg::BYTE_W-1:0] rdata
);

  localparam int AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int NUM_ADR = 1 << nbce_pkg::BYTE_W;

  logic [AW-1:0]               mod_lut [NUM_ADR];
  logic [AW-1:0]               idx;
  logic [nbce_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]        valid;
  logic [nbce_pkg::BYTE_W-1:0] rdata_raw;
  logic                        rvalid;

  // Byte address folded onto the memory depth, as a constant table.
  for (genvar i = 0; i < NUM_ADR; i++) begin : g_mod
    localparam int Rem = i % MEM_DEPTH;
    assign mod_lut[i] = AW'(Rem);
  end

  assign idx = mod_lut[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_raw <= mem[idx];
      rvalid    <= valid[idx];
    end
  end

  assign rdata = rvalid ? rdata_raw : '0;

endmodule

>>> hw/rtl/nbce_checker.sv
// ----------------------------------------------------------------------------
// nbce_checker: port-level checks of the nine-bit CPU execute step
// Watches the result stream; checks reset behaviour, result holding, that a
// halted result has no read data and keeps the previous result's state.
// ----------------------------------------------------------------------------
module nbce_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [nbce_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic        seen;
  logic [9:0]  last_pc;
  logic [32:0] last_state;
  logic        out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_acc) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_pc    <= m_axis_tdata[9:0];
      last_state <= m_axis_tdata[43:11];
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_halt_no_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[51:44] == 8'h00)
    else $error("halted result carries read data");

  a_halt_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_acc && m_axis_tdata[10] && seen |->
      m_axis_tdata[9:0] == last_pc && m_axis_tdata[43:11] == last_state)
    else $error("halted item changed machine state");

endmodule

bind nine_bit_cpu_execute_step nbce_checker u_nbce_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
